>>> rtl/core/assert_macros.svh
// Assertion macros shared by the ring FIFO RTL.
// Defining NO_ASSERTIONS turns every macro into an empty body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// The condition holds at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("invariant violated");
// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication violated");
// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");
`else
`define ASSERT_HOLDS(lbl, clk, rst_n, cond)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/brf_pkg.sv
// Shared types and constants of the byte ring FIFO with peek.
// No dependencies; every module of the block imports it.
package brf_pkg;

    localparam int DEPTH_DEFAULT     = 4096;
    localparam int MAX_BURST_DEFAULT = 64;
    localparam int CAPACITY_RESET    = 4096;
    localparam int CFG_W             = 13;
    localparam int ADDR_W            = 16;

    localparam int CQ_DEPTH = 4;
    localparam int CQ_PW    = 2;
    localparam int CQ_CW    = 3;
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PW    = 2;
    localparam int OQ_CW    = 3;

    localparam logic [2:0] MODE_WRITE   = 3'd0;
    localparam logic [2:0] MODE_READ    = 3'd1;
    localparam logic [2:0] MODE_PEEK    = 3'd2;
    localparam logic [2:0] MODE_SKIP    = 3'd3;
    localparam logic [2:0] MODE_ADVANCE = 3'd4;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  data_in;
        logic [6:0]  count;
        logic [11:0] offset;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  data_out;
        logic [6:0]  moved;
        logic        last;
        logic [11:0] fill_level;
        logic [11:0] free_space;
    } t_result;

    typedef enum logic [1:0] {
        CMD_SINGLE,
        CMD_WRITE,
        CMD_READ
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind         kind;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
        logic [6:0]        count;
        t_result           res;
    } t_cmd;

endpackage

>>> rtl/core/brf_front.sv
// Front end: owns the pointers, fill level and burst state, classifies each
// item and turns it into one command for the back end. Uses brf_pkg.
`include "assert_macros.svh"
module brf_front import brf_pkg::*; #(
    parameter int DEPTH     = DEPTH_DEFAULT,
    parameter int MAX_BURST = MAX_BURST_DEFAULT,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_push,
    input  t_in_item         i_item,
    input  logic             i_cq_full,
    output logic             o_cmd_push,
    output t_cmd             o_cmd,
    output logic [CW-1:0]    o_cap
);

    localparam int XW      = (CW > 12) ? CW : 12;
    localparam int CAP_RST = (DEPTH < CAPACITY_RESET) ? DEPTH : CAPACITY_RESET;
    localparam logic [6:0] MB = 7'(MAX_BURST);

    logic [AW-1:0] r_wr_idx, n_wr_idx;
    logic [AW-1:0] r_rd_idx, n_rd_idx;
    logic [AW-1:0] r_fill, n_fill;
    logic [CW-1:0] r_cap, n_cap;
    logic [6:0]    r_burst_left, n_burst_left;
    logic          r_burst_acc, n_burst_acc;

    logic          accept;
    logic [6:0]    cnt_sat;
    logic [6:0]    bl_after;
    logic          bl_start;
    logic          acc;
    logic [XW-1:0] cnt_x, off_x, fill_x, cap_x, free_x, n_x, fill_new_x, free_new_x;
    logic [31:0]   cap_raw;
    logic [31:0]   cap_eff;
    t_cmd          cmd;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] idx,
                                               input logic [CW-1:0] step,
                                               input logic [CW-1:0] cap);
        logic [CW:0] s;
        s = (CW+1)'(idx) + (CW+1)'(step);
        if (s >= (CW+1)'(cap)) begin
            s = s - (CW+1)'(cap);
        end
        return s[AW-1:0];
    endfunction

    assign accept = i_push && !i_cq_full;

    always_comb begin
        cnt_sat  = (i_item.count > MB) ? MB : i_item.count;
        cnt_x    = XW'(cnt_sat);
        off_x    = XW'(i_item.offset);
        fill_x   = XW'(r_fill);
        cap_x    = XW'(r_cap);
        free_x   = cap_x - XW'(1) - fill_x;

        n_wr_idx     = r_wr_idx;
        n_rd_idx     = r_rd_idx;
        n_fill       = r_fill;
        n_cap        = r_cap;
        n_burst_left = r_burst_left;
        n_burst_acc  = r_burst_acc;

        cmd          = '0;
        cmd.kind     = CMD_SINGLE;
        cmd.res.last = 1'b1;
        n_x          = '0;
        bl_start     = 1'b0;
        bl_after     = '0;
        acc          = 1'b0;

        if (accept) begin
            if (i_item.mode != MODE_WRITE) begin
                n_burst_left = '0;
            end
            case (i_item.mode)
                MODE_WRITE: begin
                    bl_start = (r_burst_left == '0);
                    // A burst start of length zero answers once and stores nothing.
                    if (!(bl_start && cnt_sat == '0)) begin
                        acc          = bl_start ? (cnt_x <= free_x) : r_burst_acc;
                        bl_after     = (bl_start ? cnt_sat : r_burst_left) - 7'd1;
                        n_burst_left = bl_after;
                        n_burst_acc  = acc;
                        cmd.res.last = (bl_after == '0);
                        if (acc && free_x != '0) begin
                            cmd.kind      = CMD_WRITE;
                            cmd.addr      = ADDR_W'(r_wr_idx);
                            cmd.data      = i_item.data_in;
                            cmd.res.moved = 7'd1;
                            n_wr_idx      = wrap_add(r_wr_idx, CW'(1), r_cap);
                            n_fill        = r_fill + AW'(1);
                        end
                    end
                end
                MODE_READ: begin
                    if (cnt_sat != '0 && fill_x >= cnt_x) begin
                        cmd.kind      = CMD_READ;
                        cmd.addr      = ADDR_W'(r_rd_idx);
                        cmd.count     = cnt_sat;
                        cmd.res.moved = cnt_sat;
                        n_rd_idx      = wrap_add(r_rd_idx, CW'(cnt_sat), r_cap);
                        n_fill        = r_fill - AW'(cnt_sat);
                    end
                end
                MODE_PEEK: begin
                    if (off_x < fill_x && cnt_sat != '0) begin
                        n_x = fill_x - off_x;
                        if (n_x > cnt_x) begin
                            n_x = cnt_x;
                        end
                        cmd.kind      = CMD_READ;
                        cmd.addr      = ADDR_W'(wrap_add(r_rd_idx, CW'(i_item.offset), r_cap));
                        cmd.count     = 7'(n_x);
                        cmd.res.moved = 7'(n_x);
                    end
                end
                MODE_SKIP: begin
                    n_x           = (cnt_x < fill_x) ? cnt_x : fill_x;
                    n_rd_idx      = wrap_add(r_rd_idx, CW'(n_x), r_cap);
                    n_fill        = r_fill - AW'(n_x);
                    cmd.res.moved = 7'(n_x);
                end
                MODE_ADVANCE: begin
                    n_x           = (cnt_x < free_x) ? cnt_x : free_x;
                    n_wr_idx      = wrap_add(r_wr_idx, CW'(n_x), r_cap);
                    n_fill        = r_fill + AW'(n_x);
                    cmd.res.moved = 7'(n_x);
                end
                default: begin
                end
            endcase
        end

        // Every result reports the levels after the whole item.
        fill_new_x         = XW'(n_fill);
        free_new_x         = cap_x - XW'(1) - fill_new_x;
        cmd.res.fill_level = fill_new_x[11:0];
        cmd.res.free_space = free_new_x[11:0];

        // A capacity write empties the FIFO; zero acts as one, large values clamp.
        cap_raw = 32'(i_cfg_data);
        if (cap_raw == 32'd0) begin
            cap_eff = 32'd1;
        end else if (cap_raw > 32'(DEPTH)) begin
            cap_eff = 32'(DEPTH);
        end else begin
            cap_eff = cap_raw;
        end
        if (i_cfg_valid) begin
            n_cap        = CW'(cap_eff);
            n_wr_idx     = '0;
            n_rd_idx     = '0;
            n_fill       = '0;
            n_burst_left = '0;
            n_burst_acc  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx     <= '0;
            r_rd_idx     <= '0;
            r_fill       <= '0;
            r_cap        <= CW'(CAP_RST);
            r_burst_left <= '0;
            r_burst_acc  <= 1'b0;
        end else begin
            r_wr_idx     <= n_wr_idx;
            r_rd_idx     <= n_rd_idx;
            r_fill       <= n_fill;
            r_cap        <= n_cap;
            r_burst_left <= n_burst_left;
            r_burst_acc  <= n_burst_acc;
        end
    end

    assign o_cmd_push = accept && !i_cfg_valid;
    assign o_cmd      = cmd;
    assign o_cap      = r_cap;

    `ASSERT_HOLDS(a_fill_bound, i_clk, i_rst_n, (CW'(r_fill) < r_cap) && (CW'(r_wr_idx) < r_cap) && (CW'(r_rd_idx) < r_cap))
    `ASSERT_HOLDS(a_fill_matches_ptrs, i_clk, i_rst_n, (r_wr_idx >= r_rd_idx) ? (r_fill == r_wr_idx - r_rd_idx) : (CW'(r_fill) == r_cap - CW'(r_rd_idx - r_wr_idx)))

endmodule

>>> rtl/core/brf_cmd_queue.sv
// Short command queue that decouples the front end from the back end.
// Uses t_cmd and the queue sizes from brf_pkg.
module brf_cmd_queue import brf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_head
);

    t_cmd             r_slot [CQ_DEPTH];
    logic [CQ_PW-1:0] r_wp;
    logic [CQ_PW-1:0] r_rp;
    logic [CQ_CW-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CQ_CW'(CQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + CQ_PW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + CQ_PW'(1);
            end
            r_cnt <= r_cnt + CQ_CW'(do_push) - CQ_CW'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_data;
        end
    end

endmodule

>>> rtl/core/brf_back.sv
// Back end: executes commands on the byte memory, one beat per cycle while
// the small output queue that buffers its results has room. Uses brf_pkg.
`include "assert_macros.svh"
module brf_back import brf_pkg::*; #(
    parameter int DEPTH = DEPTH_DEFAULT,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [CW-1:0] i_cap,
    input  logic          i_cq_empty,
    input  t_cmd          i_cq_head,
    output logic          o_cq_pop,
    input  logic          i_pop,
    output logic          o_empty,
    output t_result       o_result
);

    localparam int NW = OQ_CW + 1;

    typedef enum logic {
        ST_IDLE,
        ST_STREAM
    } t_state;

    t_state           r_state;
    t_cmd             r_cur;
    logic [AW-1:0]    r_addr;
    logic [6:0]       r_left;
    logic             r_p1_vld;
    logic             r_p1_mem;
    t_result          r_p1_res;
    logic [7:0]       r_mem [DEPTH];
    logic [7:0]       r_rd_data;
    t_result          r_oq [OQ_DEPTH];
    logic [OQ_PW-1:0] r_oq_wp;
    logic [OQ_PW-1:0] r_oq_rp;
    logic [OQ_CW-1:0] r_oq_cnt;

    t_cmd          src_cmd;
    logic [AW-1:0] src_addr;
    logic [6:0]    src_left;
    logic          src_vld;
    logic          room;
    logic          issue;
    logic          last_beat;
    logic [CW-1:0] addr_inc;
    logic [AW-1:0] addr_next;
    t_result       p1_res_in;
    t_result       p1_out;
    logic          oq_pop;

    always_comb begin
        if (r_state == ST_STREAM) begin
            src_cmd  = r_cur;
            src_addr = r_addr;
            src_left = r_left;
        end else begin
            src_cmd  = i_cq_head;
            src_addr = i_cq_head.addr[AW-1:0];
            src_left = i_cq_head.count;
        end
        src_vld   = (r_state == ST_STREAM) || !i_cq_empty;
        // Leave a slot free for the beat already in the read stage.
        room      = (NW'(r_oq_cnt) + NW'(r_p1_vld)) < NW'(OQ_DEPTH);
        issue     = src_vld && room;
        last_beat = (src_cmd.kind != CMD_READ) || (src_left <= 7'd1);
        addr_inc  = CW'(src_addr) + CW'(1);
        addr_next = (addr_inc == i_cap) ? '0 : addr_inc[AW-1:0];
        // Only the final beat of a command carries the command's last flag.
        p1_res_in      = src_cmd.res;
        p1_res_in.last = last_beat && src_cmd.res.last;
    end

    assign o_cq_pop = issue && (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_p1_vld <= 1'b0;
        end else begin
            r_p1_vld <= issue;
            if (issue) begin
                r_state <= last_beat ? ST_IDLE : ST_STREAM;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_cur    <= src_cmd;
            r_addr   <= addr_next;
            r_left   <= src_left - 7'd1;
            r_p1_mem <= (src_cmd.kind == CMD_READ);
            r_p1_res <= p1_res_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue && src_cmd.kind == CMD_WRITE) begin
            r_mem[src_addr] <= src_cmd.data;
        end
        r_rd_data <= r_mem[src_addr];
    end

    always_comb begin
        p1_out          = r_p1_res;
        p1_out.data_out = r_p1_mem ? r_rd_data : 8'd0;
    end

    assign oq_pop   = i_pop && (r_oq_cnt != '0);
    assign o_empty  = (r_oq_cnt == '0);
    assign o_result = r_oq[r_oq_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wp  <= '0;
            r_oq_rp  <= '0;
            r_oq_cnt <= '0;
        end else begin
            if (r_p1_vld) begin
                r_oq_wp <= r_oq_wp + OQ_PW'(1);
            end
            if (oq_pop) begin
                r_oq_rp <= r_oq_rp + OQ_PW'(1);
            end
            r_oq_cnt <= r_oq_cnt + OQ_CW'(r_p1_vld) - OQ_CW'(oq_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_p1_vld) begin
            r_oq[r_oq_wp] <= p1_out;
        end
    end

    `ASSERT_IMPL(a_oq_has_room, i_clk, i_rst_n, r_p1_vld, r_oq_cnt < OQ_CW'(OQ_DEPTH))
    `ASSERT_IMPL(a_stream_is_read, i_clk, i_rst_n, r_state == ST_STREAM, (r_left != '0) && (r_cur.kind == CMD_READ))
    `ASSERT_NEXT(a_stream_enter, i_clk, i_rst_n, issue && !last_beat, r_state == ST_STREAM)

endmodule

>>> rtl/core/byte_ring_fifo_with_peek.sv
// Top level of the byte ring FIFO with peek.
// Instantiates brf_front, brf_cmd_queue and brf_back; uses brf_pkg.
//
// Usage. Requests enter on a queue-style channel: an item on i_item is taken at
// a clock edge where push is high and full is low. Results leave the same way:
// o_result holds the oldest result while empty is low and is taken at an edge
// where pop is high. The capacity register is written over its own channel
// (i_cfg_valid, o_cfg_ready, i_cfg_data); o_cfg_ready is always high, and a
// write clears both pointers and any burst in progress. Write it only while
// the block is idle.
// The first result of an item passes the command queue, the read stage and the
// output queue before it shows on o_result. Throughput: one item per cycle for
// single-result items while full is low; a read or peek of n bytes occupies the
// back end for n beats, one byte per cycle while the output queue has room,
// bounded by the single read port of the byte memory. The front end keeps taking
// items while the back end streams, until the four-entry command queue fills.
// Reset: pointers, fill level and burst state clear at once and capacity comes
// up at its reset value; the byte memory is not cleared and needs no pass.
// When the receiver stops popping, the four-entry output queue fills, the back
// end stops issuing beats, the command queue fills and full rises. No beat is
// lost or repeated.
module byte_ring_fifo_with_peek import brf_pkg::*; #(
    parameter int DEPTH     = DEPTH_DEFAULT,
    parameter int MAX_BURST = MAX_BURST_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  t_in_item         i_item,
    output logic             empty,
    input  logic             pop,
    output t_result          o_result,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int CW = $clog2(DEPTH + 1);

    // Front to queue, queue to back.
    logic          cmd_push;
    t_cmd          cmd_in;
    logic          cq_full;
    logic          cq_empty;
    logic          cq_pop;
    t_cmd          cq_head;
    logic [CW-1:0] cap;

    assign o_cfg_ready = 1'b1;
    assign full        = cq_full;

    brf_front #(
        .DEPTH     (DEPTH),
        .MAX_BURST (MAX_BURST)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .i_item      (i_item),
        .i_cq_full   (cq_full),
        .o_cmd_push  (cmd_push),
        .o_cmd       (cmd_in),
        .o_cap       (cap)
    );

    // The queue lets the front keep classifying while the back streams bytes.
    brf_cmd_queue u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cq_full),
        .i_pop   (cq_pop),
        .o_empty (cq_empty),
        .o_head  (cq_head)
    );

    brf_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cap      (cap),
        .i_cq_empty (cq_empty),
        .i_cq_head  (cq_head),
        .o_cq_pop   (cq_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_result   (o_result)
    );

endmodule
